// ----- design/swm_pkg.sv -----
// swm_pkg: shared types and constants for the stack with middle operations
// depends on nothing; imported by the interfaces and all modules
`default_nettype none

package swm_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        REQ_PUSH     = 3'd0,
        REQ_POP      = 3'd1,
        REQ_PEEK     = 3'd2,
        REQ_IS_EMPTY = 3'd3,
        REQ_FIND_MID = 3'd4,
        REQ_DEL_MID  = 3'd5
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status_code;

    typedef struct packed {
        logic        [2:0]  req_type;
        logic signed [31:0] push_value;
    } t_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] read_value;
        logic               is_empty;
        logic        [4:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/swm_if.sv -----
// swm_req_if, swm_rsp_if: valid/ready channels for requests and responses
// depends on swm_pkg for the payload types
`default_nettype none

interface swm_req_if;
    import swm_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface swm_rsp_if;
    import swm_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/swm_ctrl.sv -----
// swm_ctrl: controller state machine, sequences capture and execute of a request
// depends on swm_pkg for the command type
`default_nettype none

module swm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output swm_pkg::t_dp_cmd      o_cmd
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   slot_free;

    assign slot_free   = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

`default_nettype wire

// ----- design/swm_dp.sv -----
// swm_dp: datapath with the entry cells, count, request and response registers
// depends on swm_pkg for types, codes and depth
`default_nettype none

module swm_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire swm_pkg::t_dp_cmd i_cmd,
    input  wire swm_pkg::t_req    i_req,
    output swm_pkg::t_rsp         o_rsp,
    output swm_pkg::t_dp_stat     o_stat
);
    import swm_pkg::*;

    logic signed [31:0] r_entries [DEPTH];
    t_req               r_req;
    t_rsp               r_rsp, n_rsp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   count_m1;
    logic [ADDR_W-1:0]  top_addr, mid_addr, rd_addr, wr_addr;
    logic               cnt_zero, cnt_full;
    logic               push_we, del_we;
    logic [31:0]        cnt_ext;

    assign cnt_zero = (r_count == '0);
    assign cnt_full = (r_count >= CNT_W'(DEPTH));
    assign count_m1 = r_count - CNT_W'(1);
    assign top_addr = count_m1[ADDR_W-1:0];
    assign mid_addr = top_addr >> 1;
    assign wr_addr  = r_count[ADDR_W-1:0];
    assign rd_addr  = (r_req.req_type == REQ_PEEK) ? top_addr : mid_addr;

    always_comb begin
        n_count = r_count;
        push_we = 1'b0;
        del_we  = 1'b0;
        n_rsp   = '0;
        n_rsp.status = ST_OK;
        unique case (r_req.req_type)
            REQ_PUSH: begin
                if (cnt_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    push_we = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP: begin
                if (cnt_zero) n_rsp.status = ST_EMPTY;
                else          n_count = count_m1;
            end
            REQ_PEEK, REQ_FIND_MID: begin
                if (cnt_zero) n_rsp.status = ST_EMPTY;
                else          n_rsp.read_value = r_entries[rd_addr];
            end
            REQ_DEL_MID: begin
                if (cnt_zero) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    del_we  = 1'b1;
                    n_count = count_m1;
                end
            end
            default: begin
            end
        endcase
        cnt_ext           = 32'(n_count);
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.entry_count = cnt_ext[4:0];
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [31:0] shift_src;
            logic               shift_en;
            if (g == DEPTH - 1) begin : g_last
                assign shift_src = r_entries[g];
                assign shift_en  = 1'b0;
            end else begin : g_mid
                assign shift_src = r_entries[g+1];
                assign shift_en  = (ADDR_W'(g) >= mid_addr) &&
                                   (CNT_W'(g + 1) < r_count);
            end
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    if (push_we && (wr_addr == ADDR_W'(g))) begin
                        r_entries[g] <= r_req.push_value;
                    end else if (del_we && shift_en) begin
                        r_entries[g] <= shift_src;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_req;
        if (i_cmd.exec)    r_rsp <= n_rsp;
    end

    assign o_rsp        = r_rsp;
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

// ----- design/stack_with_middle_ops.sv -----
// stack_with_middle_ops: bounded stack of signed words with find and delete middle
// flow: capture into the request register, then execute into the response register
// when the response slot is free; the controller takes no new request before execute;
// delete-middle shifts the cells above the middle down in the execute cycle
// reset: synchronous, count cleared to zero, entry cells hold no reset value
// depends on swm_pkg, swm_if, swm_ctrl and swm_dp
`default_nettype none

module stack_with_middle_ops (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swm_req_if.sink    i_req,
    swm_rsp_if.source  o_rsp
);
    import swm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    swm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.payload),
        .o_rsp   (o_rsp.payload),
        .o_stat  (stat)
    );

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> (!o_rsp.valid || o_rsp.ready))
        else $error("execute while response slot occupied");

    a_exec_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_rsp.valid)
        else $error("execute without response");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (!i_req.ready && !cmd.capture))
        else $error("request taken while one in flight");

endmodule

`default_nettype wire
